[hdl/cag_pkg.sv]
// Shared types and constants for the cave automaton generation block.
// Holds grid sizes, request codes, register map and the control structs.
// No dependencies.
`timescale 1ns / 1ps

package cag_pkg;

    // Grid geometry
    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;
    localparam int ROW_W    = 6;   // width of the row field
    localparam int COL_W    = 6;   // width of the column field
    localparam int SIZE_W   = 7;   // width of the grid size registers
    localparam int LIMIT_W  = 4;   // width of the limit registers
    localparam int COUNT_W  = 4;   // neighbour count, 0 to 8
    localparam int KIND_W   = 2;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_GEN   = 2'd2;

    // Register map, index taken from paddr[3:2]
    localparam logic [1:0] REG_LIMIT_BIRTH = 2'd0;
    localparam logic [1:0] REG_LIMIT_DEATH = 2'd1;
    localparam logic [1:0] REG_GRID_ROWS   = 2'd2;
    localparam logic [1:0] REG_GRID_COLS   = 2'd3;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Reset values of the registers
    localparam logic [LIMIT_W-1:0] RST_LIMIT_BIRTH = 4'd4;
    localparam logic [LIMIT_W-1:0] RST_LIMIT_DEATH = 4'd3;
    localparam logic [SIZE_W-1:0]  RST_GRID_ROWS   = 7'd64;
    localparam logic [SIZE_W-1:0]  RST_GRID_COLS   = 7'd64;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic              cell_in;
    } cag_req_t;

    typedef struct packed {
        logic cell_out;
        logic range_error;
    } cag_rsp_t;

    typedef struct packed {
        logic [LIMIT_W-1:0] limit_birth;
        logic [LIMIT_W-1:0] limit_death;
        logic [SIZE_W-1:0]  grid_rows;
        logic [SIZE_W-1:0]  grid_cols;
    } cag_cfg_t;

    // Row memory read address source
    typedef enum logic [1:0] {
        RD_REQ  = 2'd0,   // row of the captured request
        RD_GEN0 = 2'd1,   // current generation row
        RD_GEN1 = 2'd2,   // current row plus one
        RD_GEN2 = 2'd3    // current row plus two
    } rd_sel_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic    cap;         // capture request, clear counters
        logic    rd_en;       // issue a row read
        rd_sel_t rd_sel;
        logic    above_ones;  // row above the grid counts as alive
        logic    load_cur;    // load current row from read data
        logic    load_below;  // load row below from read data or ones
        logic    cell_step;   // update one cell, advance column
        logic    row_adv;     // write back row, shift window, advance row
        logic    acc_wr;      // write the requested cell
        logic    res_load;    // present the result
    } cag_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              in_range;
        logic              last_col;
        logic              last_row;
    } cag_sts_t;

    // Clamp a grid size register to 1..max
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] max);
        logic [SIZE_W-1:0] r;
        begin
            if (v == '0)
            begin
                r = SIZE_W'(1);
            end
            else if (v > max)
            begin
                r = max;
            end
            else
            begin
                r = v;
            end
            return r;
        end
    endfunction

endpackage

[hdl/cag_regs.sv]
// Configuration register bank on an APB-style port.
// Depends on cag_pkg for the register map and the configuration struct.
`timescale 1ns / 1ps

module cag_regs
    import cag_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output cag_cfg_t              cfg
);

    cag_cfg_t   cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];

    // Write the addressed register in the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.limit_birth <= RST_LIMIT_BIRTH;
            cfg_reg.limit_death <= RST_LIMIT_DEATH;
            cfg_reg.grid_rows   <= RST_GRID_ROWS;
            cfg_reg.grid_cols   <= RST_GRID_COLS;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_LIMIT_BIRTH: cfg_reg.limit_birth <= pwdata[LIMIT_W-1:0];
                REG_LIMIT_DEATH: cfg_reg.limit_death <= pwdata[LIMIT_W-1:0];
                REG_GRID_ROWS:   cfg_reg.grid_rows   <= pwdata[SIZE_W-1:0];
                REG_GRID_COLS:   cfg_reg.grid_cols   <= pwdata[SIZE_W-1:0];
                default:         cfg_reg.grid_cols   <= cfg_reg.grid_cols;
            endcase
        end
    end

    // Return the addressed register
    always_comb
    begin
        case (reg_idx)
            REG_LIMIT_BIRTH: prdata = APB_DATA_W'(cfg_reg.limit_birth);
            REG_LIMIT_DEATH: prdata = APB_DATA_W'(cfg_reg.limit_death);
            REG_GRID_ROWS:   prdata = APB_DATA_W'(cfg_reg.grid_rows);
            REG_GRID_COLS:   prdata = APB_DATA_W'(cfg_reg.grid_cols);
            default:         prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

[hdl/cag_ctrl.sv]
// Sequencing state machine for requests and generation sweeps.
// Depends on cag_pkg for request codes and the command/status structs.
`timescale 1ns / 1ps

module cag_ctrl
    import cag_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [KIND_W-1:0] start_kind,
    input  cag_sts_t          sts,
    output cag_cmd_t          cmd,
    output logic              busy
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_ACC_RD = 9'b000000010,
        S_ACC    = 9'b000000100,
        S_RESP   = 9'b000001000,
        S_G_RD0  = 9'b000010000,
        S_G_RD1  = 9'b000100000,
        S_FETCH  = 9'b001000000,
        S_CELL   = 9'b010000000,
        S_WB     = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Decode commands and next state
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RD_REQ;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.cap = 1'b1;
                    if (start_kind == KIND_GEN)
                    begin
                        state_next = S_G_RD0;
                    end
                    else if (start_kind == KIND_WRITE || start_kind == KIND_READ)
                    begin
                        state_next = S_ACC_RD;
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
            end
            S_ACC_RD:
            begin
                if (sts.in_range)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_REQ;
                    state_next = S_ACC;
                end
                else
                begin
                    // drop the access, flag it
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_ACC:
            begin
                cmd.acc_wr   = (sts.kind == KIND_WRITE);
                cmd.res_load = 1'b1;
                state_next   = S_IDLE;
            end
            S_RESP:
            begin
                cmd.res_load = 1'b1;
                state_next   = S_IDLE;
            end
            S_G_RD0:
            begin
                cmd.above_ones = 1'b1;
                cmd.rd_en      = 1'b1;
                cmd.rd_sel     = RD_GEN0;
                state_next     = S_G_RD1;
            end
            S_G_RD1:
            begin
                cmd.load_cur = 1'b1;
                cmd.rd_en    = 1'b1;
                cmd.rd_sel   = RD_GEN1;
                state_next   = S_FETCH;
            end
            S_FETCH:
            begin
                cmd.load_below = 1'b1;
                state_next     = S_CELL;
            end
            S_CELL:
            begin
                cmd.cell_step = 1'b1;
                if (sts.last_col)
                begin
                    state_next = S_WB;
                end
            end
            S_WB:
            begin
                cmd.row_adv = 1'b1;
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = RD_GEN2;
                if (sts.last_row)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    state_next = S_FETCH;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

[hdl/cag_dpath.sv]
// Datapath: row memory, three-row window, neighbour count and result registers.
// Depends on cag_pkg for widths, codes and the command/status structs.
`timescale 1ns / 1ps

module cag_dpath
    import cag_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cag_req_t req,
    input  cag_cfg_t cfg,
    input  cag_cmd_t cmd,
    output cag_sts_t sts,
    output cag_rsp_t rsp,
    output logic     done
);

    // Row memory, one row of cells per entry
    logic [MAX_COLS-1:0] mem [MAX_ROWS];
    logic [MAX_ROWS-1:0] row_vld_reg;
    logic [MAX_COLS-1:0] mem_q_reg;
    logic                vld_q_reg;

    cag_req_t            req_reg;
    logic [ROW_W-1:0]    row_reg;
    logic [COL_W-1:0]    col_reg;
    logic [MAX_COLS-1:0] above_reg;
    logic [MAX_COLS-1:0] cur_reg;
    logic [MAX_COLS-1:0] below_reg;
    cag_rsp_t            rsp_reg;
    logic                done_reg;

    logic [SIZE_W-1:0]   nr;
    logic [SIZE_W-1:0]   nc;
    logic [ROW_W-1:0]    rd_addr;
    logic [MAX_COLS-1:0] rd_row;
    logic [MAX_COLS-1:0] acc_row;
    logic                wr_en;
    logic [ROW_W-1:0]    wr_addr;
    logic [MAX_COLS-1:0] wr_data;
    logic                in_range;
    logic                last_col;
    logic                last_row;
    logic                next_row_ok;
    logic                left_ok;
    logic [COL_W-1:0]    cm1;
    logic [COL_W-1:0]    cp1;
    logic [7:0]          nb;
    logic [COUNT_W-1:0]  count;
    logic                alive;
    logic                cell_new;
    cag_rsp_t            rsp_next;

    assign nr = clamp_size(cfg.grid_rows, SIZE_W'(MAX_ROWS));
    assign nc = clamp_size(cfg.grid_cols, SIZE_W'(MAX_COLS));

    // Status towards the controller
    assign in_range    = ({1'b0, req_reg.row} < nr) && ({1'b0, req_reg.col} < nc);
    assign last_col    = ({1'b0, col_reg} == (nc - SIZE_W'(1)));
    assign last_row    = ({1'b0, row_reg} == (nr - SIZE_W'(1)));
    assign next_row_ok = (({1'b0, row_reg} + SIZE_W'(1)) < nr);

    assign sts.kind     = req_reg.kind;
    assign sts.in_range = in_range;
    assign sts.last_col = last_col;
    assign sts.last_row = last_row;

    // Select read address
    always_comb
    begin
        case (cmd.rd_sel)
            RD_REQ:  rd_addr = req_reg.row;
            RD_GEN0: rd_addr = row_reg;
            RD_GEN1: rd_addr = row_reg + ROW_W'(1);
            RD_GEN2: rd_addr = row_reg + ROW_W'(2);
            default: rd_addr = row_reg;
        endcase
    end

    // Never-written rows read as dead
    assign rd_row = vld_q_reg ? mem_q_reg : '0;

    // Replace one cell of the fetched row for a write request
    always_comb
    begin
        acc_row               = rd_row;
        acc_row[req_reg.col]  = req_reg.cell_in;
    end

    assign wr_en   = cmd.acc_wr | cmd.row_adv;
    assign wr_addr = cmd.acc_wr ? req_reg.row : row_reg;
    assign wr_data = cmd.acc_wr ? acc_row : cur_reg;

    // Memory write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    // Row valid flags and the read-side flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_vld_reg <= '0;
            vld_q_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.rd_en)
            begin
                vld_q_reg <= row_vld_reg[rd_addr] & ~(wr_en && wr_addr == rd_addr);
            end
            if (wr_en)
            begin
                row_vld_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // Neighbour count; positions off the grid count as alive
    assign left_ok = (col_reg != '0);
    assign cm1     = col_reg - COL_W'(1);
    assign cp1     = col_reg + COL_W'(1);

    always_comb
    begin
        nb[0] = left_ok   ? above_reg[cm1] : 1'b1;
        nb[1] = above_reg[col_reg];
        nb[2] = !last_col ? above_reg[cp1] : 1'b1;
        nb[3] = left_ok   ? cur_reg[cm1]   : 1'b1;
        nb[4] = !last_col ? cur_reg[cp1]   : 1'b1;
        nb[5] = left_ok   ? below_reg[cm1] : 1'b1;
        nb[6] = below_reg[col_reg];
        nb[7] = !last_col ? below_reg[cp1] : 1'b1;
        count = {3'b000, nb[0]} + {3'b000, nb[1]} + {3'b000, nb[2]} + {3'b000, nb[3]}
              + {3'b000, nb[4]} + {3'b000, nb[5]} + {3'b000, nb[6]} + {3'b000, nb[7]};
        alive = cur_reg[col_reg];
        if (alive)
        begin
            cell_new = !(count < cfg.limit_death);
        end
        else
        begin
            cell_new = (count > cfg.limit_birth);
        end
    end

    // Hold the request; advance the sweep counters
    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            req_reg <= req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (cmd.cap)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (cmd.row_adv)
        begin
            row_reg <= row_reg + ROW_W'(1);
            col_reg <= '0;
        end
        else if (cmd.cell_step)
        begin
            col_reg <= col_reg + COL_W'(1);
        end
    end

    // Three-row window: above holds new values, current is updated in place
    always_ff @(posedge clk)
    begin
        if (cmd.above_ones)
        begin
            above_reg <= '1;
        end
        else if (cmd.row_adv)
        begin
            above_reg <= cur_reg;
        end

        if (cmd.load_cur)
        begin
            cur_reg <= rd_row;
        end
        else if (cmd.row_adv)
        begin
            cur_reg <= below_reg;
        end
        else if (cmd.cell_step)
        begin
            cur_reg[col_reg] <= cell_new;
        end

        if (cmd.load_below)
        begin
            below_reg <= next_row_ok ? rd_row : '1;
        end
    end

    // Result
    always_comb
    begin
        rsp_next.range_error = ((req_reg.kind == KIND_WRITE) || (req_reg.kind == KIND_READ))
                               && !in_range;
        rsp_next.cell_out    = (req_reg.kind == KIND_READ) && in_range && rd_row[req_reg.col];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.res_load;
        end
    end

    assign rsp  = rsp_reg;
    assign done = done_reg;

endmodule

[hdl/cave_automaton_generation_top.sv]
// Top level of the cave automaton generation block.
// Depends on cag_pkg, cag_regs, cag_ctrl and cag_dpath.
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low; its result appears
// on rsp for exactly one cycle with done high, and must be captured then:
// the receiver cannot hold it off. A cell write or read keeps the block busy
// through a row read and then the write or the result; an out-of-grid access
// or unused kind goes straight to its result. One generation is a sweep that
// reads the first two rows, then updates one cell per cycle and, for each row,
// fetches the row below before its cells and writes it back after them. A new
// request may be taken in the cycle its predecessor's result is shown. The user
// writes configuration registers only while the block is idle; it does not enforce it.

module cave_automaton_generation_top
    import cag_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  cag_req_t              req,
    output logic                  done,
    output cag_rsp_t              rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cag_cfg_t cfg;
    cag_cmd_t cmd;
    cag_sts_t sts;

    assign pready = 1'b1;

    cag_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    cag_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .start_kind (req.kind),
        .sts        (sts),
        .cmd        (cmd),
        .busy       (busy)
    );

    cag_dpath u_dpath
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cfg   (cfg),
        .cmd   (cmd),
        .sts   (sts),
        .rsp   (rsp),
        .done  (done)
    );

endmodule

[sim/tb_cave_automaton_generation_top.sv]
// Self-checking testbench for cave_automaton_generation_top: directed table, then random phases.
// Predicts each result from its own grid model or the directed table's typed outcome, and checks it field by field.
// Depends on cag_pkg and the RTL under hdl.
`timescale 1ns / 1ps

module tb_cave_automaton_generation_top;
    import cag_pkg::*;

    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;   // unused request kind

    localparam cag_rsp_t RSP_CLEAR = 2'b00;   // nothing to report
    localparam cag_rsp_t RSP_ALIVE = 2'b10;   // read of a live cell
    localparam cag_rsp_t RSP_RANGE = 2'b01;   // access outside the grid

    localparam logic CHECK_TYPED = 1'b1;
    localparam logic CHECK_MODEL = 1'b0;

    localparam int          RANDOM_PHASES = 6;
    localparam int          PHASE_ITEMS   = 20;
    localparam int          DRAIN_CYCLES  = 20;
    localparam int unsigned CYCLE_LIMIT   = 3000000;
    localparam int          REPORT_MAX    = 10;

    typedef enum logic {STEP_REQ, STEP_REG} step_kind_t;

    typedef struct packed {
        step_kind_t        op;
        cag_req_t          item;
        logic              typed;
        cag_rsp_t          outcome;
        logic [1:0]        reg_idx;
        logic [SIZE_W-1:0] value;
    } plan_step_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    cag_req_t              req;
    logic                  done;
    cag_rsp_t              rsp;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Travels with req: use a typed outcome instead of the model's
    logic     use_typed;
    cag_rsp_t typed_outcome;

    // Own copy of the grid and the registers
    logic               cave_map [MAX_ROWS][MAX_COLS];
    logic [LIMIT_W-1:0] birth_lim;
    logic [LIMIT_W-1:0] death_lim;
    logic [SIZE_W-1:0]  rows_cfg;
    logic [SIZE_W-1:0]  cols_cfg;

    cag_rsp_t    pending_outcomes [$];
    plan_step_t  directed_plan [$];
    cag_rsp_t    awaited;
    cag_rsp_t    foreseen;
    int          mismatches;
    int unsigned cycle_count;
    logic        gaps_on;

    cave_automaton_generation_top u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .req     (req),
        .done    (done),
        .rsp     (rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Grid size in use: zero acts as one, oversize acts as the maximum
    function automatic int span(input logic [SIZE_W-1:0] v, input int limit);
        if (v == '0)
        begin
            return 1;
        end
        if (int'(v) > limit)
        begin
            return limit;
        end
        return int'(v);
    endfunction

    // One generation, raster order, updated in place; outside counts as alive
    function automatic void grow_cave();
        int nr;
        int nc;
        int live;
        int rr;
        int cc;
        nr = span(rows_cfg, MAX_ROWS);
        nc = span(cols_cfg, MAX_COLS);
        for (int r = 0; r < nr; r++)
        begin
            for (int c = 0; c < nc; c++)
            begin
                live = 0;
                for (int dr = -1; dr <= 1; dr++)
                begin
                    for (int dc = -1; dc <= 1; dc++)
                    begin
                        if (dr != 0 || dc != 0)
                        begin
                            rr = r + dr;
                            cc = c + dc;
                            if (rr < 0 || cc < 0 || rr >= nr || cc >= nc)
                            begin
                                live++;
                            end
                            else
                            begin
                                live += int'(cave_map[rr][cc]);
                            end
                        end
                    end
                end
                if (cave_map[r][c])
                begin
                    if (live < int'(death_lim))
                    begin
                        cave_map[r][c] = 1'b0;
                    end
                end
                else if (live > int'(birth_lim))
                begin
                    cave_map[r][c] = 1'b1;
                end
            end
        end
    endfunction

    // Outcome of one request, applying its effect to the grid copy
    function automatic cag_rsp_t cave_outcome(input cag_req_t item);
        cag_rsp_t o;
        int       nr;
        int       nc;
        o  = RSP_CLEAR;
        nr = span(rows_cfg, MAX_ROWS);
        nc = span(cols_cfg, MAX_COLS);
        if (item.kind == KIND_WRITE || item.kind == KIND_READ)
        begin
            if (int'(item.row) >= nr || int'(item.col) >= nc)
            begin
                o.range_error = 1'b1;
            end
            else if (item.kind == KIND_WRITE)
            begin
                cave_map[item.row][item.col] = item.cell_in;
            end
            else
            begin
                o.cell_out = cave_map[item.row][item.col];
            end
        end
        else if (item.kind == KIND_GEN)
        begin
            grow_cave();
        end
        return o;
    endfunction

    function automatic plan_step_t cell_step(input logic [KIND_W-1:0] kind, input int r,
                                             input int c, input logic v, input logic typed,
                                             input cag_rsp_t outcome);
        plan_step_t s;
        s              = '0;
        s.op           = STEP_REQ;
        s.item.kind    = kind;
        s.item.row     = ROW_W'(r);
        s.item.col     = COL_W'(c);
        s.item.cell_in = v;
        s.typed        = typed;
        s.outcome      = outcome;
        return s;
    endfunction

    function automatic plan_step_t reg_step(input logic [1:0] idx, input int value);
        plan_step_t s;
        s         = '0;
        s.op      = STEP_REG;
        s.reg_idx = idx;
        s.value   = SIZE_W'(value);
        return s;
    endfunction

    // Append one row to the directed table
    function automatic void plan_add(input plan_step_t s);
        directed_plan = {directed_plan, s};
    endfunction

    function automatic logic [SIZE_W-1:0] pick_size();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            return '0;
        end
        if (pick == 1)
        begin
            return SIZE_W'($urandom_range(65, 127));
        end
        return SIZE_W'($urandom_range(1, 12));
    endfunction

    // Mostly limits that keep the cave changing, sometimes any value
    function automatic logic [LIMIT_W-1:0] pick_limit();
        if ($urandom_range(0, 9) < 7)
        begin
            return LIMIT_W'($urandom_range(2, 6));
        end
        return LIMIT_W'($urandom_range(0, 15));
    endfunction

    task automatic note_mismatch(input string field, input logic want, input logic got);
        if (mismatches < REPORT_MAX)
        begin
            $display("mismatch on %s at cycle %0d: expected %b, got %b",
                     field, cycle_count, want, got);
        end
        mismatches++;
    endtask

    // Check results, then log the request taken at this edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_outcomes.size() == 0)
                begin
                    if (mismatches < REPORT_MAX)
                    begin
                        $display("unexpected result at cycle %0d: %b", cycle_count, rsp);
                    end
                    mismatches++;
                end
                else
                begin
                    awaited = pending_outcomes.pop_front();
                    if (rsp.cell_out !== awaited.cell_out)
                    begin
                        note_mismatch("cell_out", awaited.cell_out, rsp.cell_out);
                    end
                    if (rsp.range_error !== awaited.range_error)
                    begin
                        note_mismatch("range_error", awaited.range_error, rsp.range_error);
                    end
                end
            end
            if (start && !busy)
            begin
                foreseen         = cave_outcome(req);
                pending_outcomes = {pending_outcomes, use_typed ? typed_outcome : foreseen};
            end
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Present a request and hold it until the block takes it
    task automatic cell_request(input cag_req_t item, input logic typed, input cag_rsp_t outcome);
        start         <= 1'b1;
        req           <= item;
        use_typed     <= typed;
        typed_outcome <= outcome;
        do
        begin
            @(posedge clk);
        end
        while (busy);
    endtask

    task automatic sender_gap();
        if (gaps_on && $urandom_range(0, 2) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
    endtask

    // Drop start and wait until every result is in and the block is quiet
    task automatic settle();
        start <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending_outcomes.size() != 0 || busy);
        repeat (4) @(posedge clk);
    endtask

    // Setup and access phase, then the bus returns to idle
    task automatic write_register(input logic [1:0] idx, input logic [SIZE_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= APB_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        case (idx)
            REG_LIMIT_BIRTH: birth_lim = value[LIMIT_W-1:0];
            REG_LIMIT_DEATH: death_lim = value[LIMIT_W-1:0];
            REG_GRID_ROWS:   rows_cfg  = value;
            REG_GRID_COLS:   cols_cfg  = value;
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Random request shaped by the grid in use
    task automatic random_request();
        cag_req_t item;
        int       nr;
        int       nc;
        int       pick;
        nr           = span(rows_cfg, MAX_ROWS);
        nc           = span(cols_cfg, MAX_COLS);
        pick         = $urandom_range(0, 99);
        item.cell_in = 1'($urandom_range(0, 1));
        item.row     = ROW_W'($urandom_range(0, nr - 1));
        item.col     = COL_W'($urandom_range(0, nc - 1));
        if (pick < 45)
        begin
            item.kind = KIND_WRITE;
        end
        else if (pick < 75)
        begin
            item.kind = KIND_READ;
        end
        else if (pick < 92)
        begin
            item.kind = (pick < 88) ? KIND_GEN : KIND_SPARE;
            item.row  = ROW_W'($urandom_range(0, MAX_ROWS - 1));
            item.col  = COL_W'($urandom_range(0, MAX_COLS - 1));
        end
        else
        begin
            // Push the access off the grid where the grid allows it
            item.kind = $urandom_range(0, 1) ? KIND_READ : KIND_WRITE;
            if (nr < MAX_ROWS && (nc == MAX_COLS || $urandom_range(0, 1)))
            begin
                item.row = ROW_W'($urandom_range(nr, MAX_ROWS - 1));
            end
            else if (nc < MAX_COLS)
            begin
                item.col = COL_W'($urandom_range(nc, MAX_COLS - 1));
            end
        end
        cell_request(item, CHECK_MODEL, RSP_CLEAR);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        clk           = 1'b0;
        start         = 1'b0;
        req           = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        use_typed     = 1'b0;
        typed_outcome = RSP_CLEAR;
        mismatches    = 0;
        cycle_count   = 0;
        gaps_on       = 1'b1;
        birth_lim     = RST_LIMIT_BIRTH;
        death_lim     = RST_LIMIT_DEATH;
        rows_cfg      = RST_GRID_ROWS;
        cols_cfg      = RST_GRID_COLS;
        for (int r = 0; r < MAX_ROWS; r++)
        begin
            for (int c = 0; c < MAX_COLS; c++)
            begin
                cave_map[r][c] = 1'b0;
            end
        end

        // Full grid after reset: corners, both cell values, unused kind, a generation
        plan_add(cell_step(KIND_READ,   0,  0, 1'b0, CHECK_TYPED, RSP_CLEAR));
        plan_add(cell_step(KIND_READ,  63, 63, 1'b1, CHECK_TYPED, RSP_CLEAR));
        plan_add(cell_step(KIND_WRITE, 63, 63, 1'b1, CHECK_TYPED, RSP_CLEAR));
        plan_add(cell_step(KIND_READ,  63, 63, 1'b0, CHECK_TYPED, RSP_ALIVE));
        plan_add(cell_step(KIND_WRITE,  0,  0, 1'b1, CHECK_TYPED, RSP_CLEAR));
        plan_add(cell_step(KIND_READ,   0,  0, 1'b0, CHECK_TYPED, RSP_ALIVE));
        plan_add(cell_step(KIND_WRITE,  0,  0, 1'b0, CHECK_TYPED, RSP_CLEAR));
        plan_add(cell_step(KIND_READ,   0,  0, 1'b1, CHECK_TYPED, RSP_CLEAR));
        plan_add(cell_step(KIND_SPARE, 63, 63, 1'b1, CHECK_TYPED, RSP_CLEAR));
        plan_add(cell_step(KIND_GEN,    0,  0, 1'b0, CHECK_TYPED, RSP_CLEAR));
        plan_add(cell_step(KIND_READ,   0, 63, 1'b0, CHECK_MODEL, RSP_CLEAR));
        // Shrink to 5 by 7: off-grid accesses, stored cells out of reach
        plan_add(reg_step(REG_GRID_ROWS, 5));
        plan_add(reg_step(REG_GRID_COLS, 7));
        plan_add(cell_step(KIND_WRITE,  5,  0, 1'b1, CHECK_TYPED, RSP_RANGE));
        plan_add(cell_step(KIND_READ,   0,  7, 1'b0, CHECK_TYPED, RSP_RANGE));
        plan_add(cell_step(KIND_READ,  63, 63, 1'b0, CHECK_TYPED, RSP_RANGE));
        plan_add(cell_step(KIND_WRITE,  4,  6, 1'b1, CHECK_TYPED, RSP_CLEAR));
        plan_add(cell_step(KIND_GEN,    0,  0, 1'b0, CHECK_TYPED, RSP_CLEAR));
        plan_add(cell_step(KIND_READ,   4,  6, 1'b0, CHECK_MODEL, RSP_CLEAR));
        // Limits at the top: nothing born, every live cell dies; zero rows acts as one
        plan_add(reg_step(REG_LIMIT_BIRTH, 15));
        plan_add(reg_step(REG_LIMIT_DEATH, 15));
        plan_add(reg_step(REG_GRID_ROWS, 0));
        plan_add(reg_step(REG_GRID_COLS, 127));
        plan_add(cell_step(KIND_WRITE,  0,  5, 1'b1, CHECK_TYPED, RSP_CLEAR));
        plan_add(cell_step(KIND_GEN,    0,  0, 1'b0, CHECK_TYPED, RSP_CLEAR));
        plan_add(cell_step(KIND_READ,   0,  5, 1'b0, CHECK_TYPED, RSP_CLEAR));
        plan_add(cell_step(KIND_READ,   1,  0, 1'b0, CHECK_TYPED, RSP_RANGE));
        // Limits at the bottom on a 64 by 1 column
        plan_add(reg_step(REG_LIMIT_BIRTH, 0));
        plan_add(reg_step(REG_LIMIT_DEATH, 0));
        plan_add(reg_step(REG_GRID_ROWS, 127));
        plan_add(reg_step(REG_GRID_COLS, 0));
        plan_add(cell_step(KIND_GEN,    0,  0, 1'b0, CHECK_TYPED, RSP_CLEAR));
        plan_add(cell_step(KIND_READ,  63,  0, 1'b0, CHECK_MODEL, RSP_CLEAR));
        plan_add(cell_step(KIND_READ,   0,  1, 1'b0, CHECK_TYPED, RSP_RANGE));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        foreach (directed_plan[i])
        begin
            if (directed_plan[i].op == STEP_REG)
            begin
                settle();
                write_register(directed_plan[i].reg_idx, directed_plan[i].value);
            end
            else
            begin
                sender_gap();
                cell_request(directed_plan[i].item, directed_plan[i].typed,
                             directed_plan[i].outcome);
            end
        end

        // Random phases: first on the full grid, last without gaps
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            settle();
            write_register(REG_LIMIT_BIRTH, SIZE_W'(pick_limit()));
            write_register(REG_LIMIT_DEATH, SIZE_W'(pick_limit()));
            write_register(REG_GRID_ROWS, (ph == 0) ? SIZE_W'(MAX_ROWS) : pick_size());
            write_register(REG_GRID_COLS, (ph == 0) ? SIZE_W'(MAX_COLS) : pick_size());
            gaps_on = (ph != RANDOM_PHASES - 1);
            repeat (PHASE_ITEMS)
            begin
                sender_gap();
                random_request();
            end
        end

        // Drain and watch for stray results
        start <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending_outcomes.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_outcomes.size() != 0)
        begin
            mismatches++;
        end

        if (mismatches == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
